// ===== hw/rtl/priority_tick_scheduler_semaphores_assert.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef PRIORITY_TICK_SCHEDULER_SEMAPHORES_ASSERT_SVH
`define PRIORITY_TICK_SCHEDULER_SEMAPHORES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define PTS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== hw/rtl/pts_pkg.sv =====
// Shared types, codes and constants of the tick-budget scheduler.
// Used by pts_cell, pts_sem and the top level; depends on nothing.
package pts_pkg;

    localparam int TASK_COUNT_DEF = 8;
    localparam int SEM_COUNT_DEF  = 4;
    localparam int RING_DEPTH_DEF = 8;

    localparam int TASK_IDX_W = 3;
    localparam int BUDGET_W   = 8;
    localparam int SLEEP_W    = 16;
    localparam int HZ_W       = 10;
    localparam int SEL_W      = 2;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SEM_INIT_W = 4;
    localparam int SEM_CNT_W  = 8;

    // ms*HZ/1000 is computed as ((ms*HZ) >> 3) * SLEEP_RECIP >> SLEEP_SHIFT,
    // exact for every product below 2^26.
    localparam int PROD1_W      = SLEEP_W + HZ_W;
    localparam int PRE_SHIFT    = 3;
    localparam int RECIP_W      = 24;
    localparam int PROD2_W      = PROD1_W - PRE_SHIFT + RECIP_W;
    localparam int SLEEP_SHIFT  = 30;
    localparam logic [RECIP_W-1:0] SLEEP_RECIP = 24'd8589935;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HZ       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEM_BASE = 3'd2;

    localparam logic [CFG_DATA_W-1:0] PRIO_RESET     = 64'h0101_0101_0101_0101;
    localparam logic [HZ_W-1:0]       HZ_RESET       = 10'd100;
    localparam logic [SEM_INIT_W-1:0] SEM_INIT_RESET = 4'd1;

    localparam logic signed [SEM_CNT_W-1:0] SEM_MIN = 8'sh80;
    localparam logic signed [SEM_CNT_W-1:0] SEM_MAX = 8'sh7F;

    typedef logic [TASK_IDX_W-1:0] task_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_SCHED = 3'd1,
        OP_SLEEP = 3'd2,
        OP_SEM_P = 3'd3,
        OP_SEM_V = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DEC_BUDGET,
        CMD_LOAD_SLEEP,
        CMD_SET_WAIT,
        CMD_CLR_WAIT,
        CMD_DEC_SLEEP,
        CMD_RELOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        task_idx_t            target;
        logic [SLEEP_W-1:0]   sleep_val;
    } cell_cmd_t;

    // Best candidate so far, rippling one cell per cycle down the chain.
    typedef struct packed {
        logic                 valid;
        logic [BUDGET_W-1:0]  budget;
        task_idx_t            idx;
    } token_t;

    typedef enum logic [1:0] {
        SEM_NONE,
        SEM_P,
        SEM_V
    } sem_op_t;

    typedef struct packed {
        sem_op_t              op;
        logic [SEL_W-1:0]     sel;
        task_idx_t            caller;
    } sem_cmd_t;

    typedef struct packed {
        logic                 p_block;
        logic                 v_wake;
    } sem_stat_t;

endpackage

// ===== hw/rtl/priority_tick_scheduler_semaphores.sv =====
// Top level of the tick-budget task scheduler with counting semaphores.
// Depends on pts_pkg, pts_cell, pts_sem and the assertion macro header.
//
// Usage: the input channel (in_valid/in_stall) carries one command beat
// (op, sleep_ms, sem_select); the output channel (out_valid/out_stall)
// returns exactly one result beat per command: running_task, none_runnable
// and caller_blocked. The config channel (cfg_valid/cfg_ready) writes
// registers by index and is always ready; write it only while idle.
// One command is worked on at a time; in_stall is high from acceptance
// until its result is placed in the output register. A schedule pass, run
// by every clock tick or schedule, walks a token down the chain of task
// cells, one cell per cycle. A pass that must reload budgets walks the
// chain a second time. A sleep first runs the two-step tick conversion
// multiply, a waking V first reads the wait ring, and a P or V that
// schedules nothing skips the pass. The next command is accepted once the
// machine is back in idle. A stalled result holds in the output register
// while the next command is already being worked on; that command waits
// in its finish state until the register is free. Reset clears all task
// state, loads the configured defaults and empties every wait ring.
module priority_tick_scheduler_semaphores #(
    parameter int TASK_COUNT = pts_pkg::TASK_COUNT_DEF,
    parameter int SEM_COUNT  = pts_pkg::SEM_COUNT_DEF,
    parameter int RING_DEPTH = pts_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pts_pkg::OP_W-1:0]       op,
    input  logic [pts_pkg::SLEEP_W-1:0]    sleep_ms,
    input  logic [pts_pkg::SEL_W-1:0]      sem_select,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pts_pkg::TASK_IDX_W-1:0] running_task,
    output logic                           none_runnable,
    output logic                           caller_blocked,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_LOAD_SLEEP,
        S_WAKE,
        S_DEC_SLEEP,
        S_LAUNCH,
        S_SCAN,
        S_RELOAD,
        S_FINISH
    } state_t;

    state_t                           state_reg;
    logic [pts_pkg::CFG_DATA_W-1:0]   prio_reg;
    logic [pts_pkg::HZ_W-1:0]         hz_reg;
    pts_pkg::task_idx_t               current_reg;
    logic [pts_pkg::OP_W-1:0]         op_reg;
    logic [pts_pkg::SLEEP_W-1:0]      ms_reg;
    logic [pts_pkg::SEL_W-1:0]        sel_reg;
    logic                             idle_reg;
    logic                             blocked_reg;
    logic                             reloaded_reg;
    logic [pts_pkg::PROD1_W-1:0]      prod1_reg;
    logic [pts_pkg::PROD2_W-1:0]      prod2_reg;
    logic                             out_valid_reg;
    pts_pkg::task_idx_t               out_task_reg;
    logic                             out_idle_reg;
    logic                             out_blocked_reg;

    logic [pts_pkg::PROD1_W-1:0]      prod1_next;
    logic [pts_pkg::PROD2_W-1:0]      prod2_next;
    logic [pts_pkg::SLEEP_W:0]        quot;
    logic [pts_pkg::SLEEP_W-1:0]      sleep_conv;
    logic                             sem_ok;
    logic                             cfg_we;
    pts_pkg::cell_cmd_t               cell_cmd;
    pts_pkg::sem_cmd_t                sem_cmd;
    pts_pkg::sem_stat_t               sem_stat;
    pts_pkg::task_idx_t               wake_task;
    pts_pkg::token_t                  token_chain [TASK_COUNT+1];
    pts_pkg::token_t                  chain_end;

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign running_task   = out_task_reg;
    assign none_runnable  = out_idle_reg;
    assign caller_blocked = out_blocked_reg;
    assign cfg_ready      = 1'b1;
    assign cfg_we         = cfg_valid && cfg_ready;
    assign sem_ok         = (int'(sel_reg) < SEM_COUNT);
    assign chain_end      = token_chain[TASK_COUNT];

    assign prod1_next  = pts_pkg::PROD1_W'(ms_reg) * pts_pkg::PROD1_W'(hz_reg);
    assign prod2_next  = pts_pkg::PROD2_W'(prod1_reg[pts_pkg::PROD1_W-1:pts_pkg::PRE_SHIFT])
                       * pts_pkg::PROD2_W'(pts_pkg::SLEEP_RECIP);
    assign quot        = prod2_reg[pts_pkg::PROD2_W-1:pts_pkg::SLEEP_SHIFT];
    assign sleep_conv  = quot[pts_pkg::SLEEP_W] ? '1 : quot[pts_pkg::SLEEP_W-1:0];

    always_comb
    begin
        cell_cmd.op        = pts_pkg::CMD_NONE;
        cell_cmd.target    = current_reg;
        cell_cmd.sleep_val = sleep_conv;
        sem_cmd.op         = pts_pkg::SEM_NONE;
        sem_cmd.sel        = sel_reg;
        sem_cmd.caller     = current_reg;
        token_chain[0]     = '0;
        case (state_reg)
            S_EXEC:
            begin
                case (pts_pkg::op_t'(op_reg))
                    pts_pkg::OP_TICK:
                        cell_cmd.op = pts_pkg::CMD_DEC_BUDGET;
                    pts_pkg::OP_SEM_P:
                    begin
                        if (sem_ok)
                        begin
                            sem_cmd.op = pts_pkg::SEM_P;
                            if (sem_stat.p_block)
                                cell_cmd.op = pts_pkg::CMD_SET_WAIT;
                        end
                    end
                    pts_pkg::OP_SEM_V:
                    begin
                        if (sem_ok)
                            sem_cmd.op = pts_pkg::SEM_V;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LOAD_SLEEP:
                cell_cmd.op = pts_pkg::CMD_LOAD_SLEEP;
            S_WAKE:
            begin
                cell_cmd.op     = pts_pkg::CMD_CLR_WAIT;
                cell_cmd.target = wake_task;
            end
            S_DEC_SLEEP:
                cell_cmd.op = pts_pkg::CMD_DEC_SLEEP;
            S_LAUNCH:
                token_chain[0].valid = 1'b1;
            S_RELOAD:
                cell_cmd.op = pts_pkg::CMD_RELOAD;
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < TASK_COUNT; i++)
    begin : g_cell
        pts_cell #(
            .CELL_INDEX (pts_pkg::task_idx_t'(i))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .prio    (prio_reg[pts_pkg::BUDGET_W*i +: pts_pkg::BUDGET_W]),
            .cmd     (cell_cmd),
            .tok_in  (token_chain[i]),
            .tok_out (token_chain[i+1])
        );
    end

    pts_sem #(
        .SEM_COUNT  (SEM_COUNT),
        .RING_DEPTH (RING_DEPTH)
    ) u_sem (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_init  (cfg_data[pts_pkg::SEM_INIT_W-1:0]),
        .cmd       (sem_cmd),
        .stat      (sem_stat),
        .wake_task (wake_task)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prio_reg      <= pts_pkg::PRIO_RESET;
            hz_reg        <= pts_pkg::HZ_RESET;
            current_reg   <= '0;
            idle_reg      <= 1'b0;
            blocked_reg   <= 1'b0;
            reloaded_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pts_pkg::CFG_PRIO:
                        prio_reg <= cfg_data;
                    pts_pkg::CFG_HZ:
                        hz_reg <= cfg_data[pts_pkg::HZ_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // In the finish state the output register is handled below.
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg       <= op;
                        ms_reg       <= sleep_ms;
                        sel_reg      <= sem_select;
                        idle_reg     <= 1'b0;
                        blocked_reg  <= 1'b0;
                        reloaded_reg <= 1'b0;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (pts_pkg::op_t'(op_reg))
                        pts_pkg::OP_TICK, pts_pkg::OP_SCHED:
                            state_reg <= S_DEC_SLEEP;
                        pts_pkg::OP_SLEEP:
                        begin
                            prod1_reg <= prod1_next;
                            state_reg <= S_MUL;
                        end
                        pts_pkg::OP_SEM_P:
                        begin
                            if (sem_ok && sem_stat.p_block)
                            begin
                                blocked_reg <= 1'b1;
                                state_reg   <= S_DEC_SLEEP;
                            end
                            else
                                state_reg <= S_FINISH;
                        end
                        pts_pkg::OP_SEM_V:
                        begin
                            if (sem_ok && sem_stat.v_wake)
                                state_reg <= S_WAKE;
                            else
                                state_reg <= S_FINISH;
                        end
                        default:
                            state_reg <= S_FINISH;
                    endcase
                end
                S_MUL:
                begin
                    prod2_reg <= prod2_next;
                    state_reg <= S_LOAD_SLEEP;
                end
                S_LOAD_SLEEP, S_WAKE:
                    state_reg <= S_DEC_SLEEP;
                S_DEC_SLEEP:
                    state_reg <= S_LAUNCH;
                S_LAUNCH:
                    state_reg <= S_SCAN;
                S_SCAN:
                begin
                    // The token reaches the end of the chain after passing the register of every cell.
                    if (chain_end.valid)
                    begin
                        if (chain_end.budget != '0)
                        begin
                            current_reg <= chain_end.idx;
                            state_reg   <= S_FINISH;
                        end
                        else if (reloaded_reg)
                        begin
                            idle_reg  <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else
                            state_reg <= S_RELOAD;
                    end
                end
                S_RELOAD:
                begin
                    reloaded_reg <= 1'b1;
                    state_reg    <= S_LAUNCH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_task_reg    <= current_reg;
                        out_idle_reg    <= idle_reg;
                        out_blocked_reg <= blocked_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`include "priority_tick_scheduler_semaphores_assert.svh"

    `PTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `PTS_ASSERT_IMP(a_token_in_scan, chain_end.valid, state_reg == S_SCAN)
    `PTS_ASSERT_IMP(a_single_reload, state_reg == S_RELOAD, !reloaded_reg)
    `PTS_ASSERT_IMP(a_current_range, 1'b1, int'(current_reg) < TASK_COUNT)

endmodule

// ===== hw/rtl/pts_cell.sv =====
// One task cell: budget, sleep count and blocked mark of a single task,
// plus its stage of the max-budget token chain. Depends on pts_pkg.
module pts_cell #(
    parameter pts_pkg::task_idx_t CELL_INDEX = '0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pts_pkg::BUDGET_W-1:0] prio,
    input  pts_pkg::cell_cmd_t           cmd,
    input  pts_pkg::token_t              tok_in,
    output pts_pkg::token_t              tok_out
);

    logic [pts_pkg::BUDGET_W-1:0] budget_reg;
    logic [pts_pkg::SLEEP_W-1:0]  sleep_reg;
    logic                         wait_reg;
    pts_pkg::token_t              tok_reg;
    pts_pkg::token_t              tok_next;
    logic                         runnable;
    logic                         hit;

    assign runnable = !wait_reg && (sleep_reg == '0);
    assign hit      = (cmd.target == CELL_INDEX);
    assign tok_out  = tok_reg;

    // A runnable task with a strictly larger budget takes the token, so the
    // lowest index wins a tie.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && runnable && (budget_reg > tok_in.budget))
        begin
            tok_next.budget = budget_reg;
            tok_next.idx    = CELL_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            sleep_reg     <= '0;
            wait_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            case (cmd.op)
                pts_pkg::CMD_DEC_BUDGET:
                begin
                    if (hit && (budget_reg != '0))
                        budget_reg <= budget_reg - 1'b1;
                end
                pts_pkg::CMD_LOAD_SLEEP:
                begin
                    if (hit)
                        sleep_reg <= cmd.sleep_val;
                end
                pts_pkg::CMD_SET_WAIT:
                begin
                    if (hit)
                        wait_reg <= 1'b1;
                end
                pts_pkg::CMD_CLR_WAIT:
                begin
                    if (hit)
                        wait_reg <= 1'b0;
                end
                pts_pkg::CMD_DEC_SLEEP:
                begin
                    if (sleep_reg != '0)
                        sleep_reg <= sleep_reg - 1'b1;
                end
                pts_pkg::CMD_RELOAD:
                begin
                    if (runnable)
                        budget_reg <= prio;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/pts_sem.sv =====
// Counting semaphores with one wait ring each, held in a single memory.
// Depends on pts_pkg.
module pts_sem #(
    parameter int SEM_COUNT  = pts_pkg::SEM_COUNT_DEF,
    parameter int RING_DEPTH = pts_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::SEM_INIT_W-1:0] cfg_init,
    input  pts_pkg::sem_cmd_t              cmd,
    output pts_pkg::sem_stat_t             stat,
    output pts_pkg::task_idx_t             wake_task
);

    localparam int SEM_W        = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int RING_ENTRIES = SEM_COUNT * RING_DEPTH;
    localparam int ADDR_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam logic [pts_pkg::CFG_IDX_W-1:0] CFG_SEM_LAST =
        pts_pkg::CFG_IDX_W'(int'(pts_pkg::CFG_SEM_BASE) + SEM_COUNT - 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic signed [pts_pkg::SEM_CNT_W-1:0] count_reg [SEM_COUNT];
    logic [PTR_W-1:0]                     head_reg  [SEM_COUNT];
    logic [PTR_W-1:0]                     tail_reg  [SEM_COUNT];
    pts_pkg::task_idx_t                   ring_mem  [RING_ENTRIES];
    pts_pkg::task_idx_t                   wake_reg;

    logic [SEM_W-1:0]                     sel_idx;
    logic signed [pts_pkg::SEM_CNT_W-1:0] cnt;
    logic signed [pts_pkg::SEM_CNT_W-1:0] dec_cnt;
    logic signed [pts_pkg::SEM_CNT_W-1:0] inc_cnt;
    logic [PTR_W-1:0]                     head;
    logic [PTR_W-1:0]                     tail;
    logic [ADDR_W-1:0]                    head_addr;
    logic [ADDR_W-1:0]                    tail_addr;
    logic                                 do_p;
    logic                                 do_v;
    logic                                 cfg_hit;
    logic [pts_pkg::CFG_IDX_W-1:0]        cfg_sem;

    assign sel_idx   = cmd.sel[SEM_W-1:0];
    assign cnt       = count_reg[sel_idx];
    assign head      = head_reg[sel_idx];
    assign tail      = tail_reg[sel_idx];
    assign dec_cnt   = (cnt != pts_pkg::SEM_MIN) ? cnt - 8'sd1 : cnt;
    assign inc_cnt   = (cnt != pts_pkg::SEM_MAX) ? cnt + 8'sd1 : cnt;
    assign head_addr = ADDR_W'(int'(sel_idx) * RING_DEPTH + int'(head));
    assign tail_addr = ADDR_W'(int'(sel_idx) * RING_DEPTH + int'(tail));
    assign do_p      = (cmd.op == pts_pkg::SEM_P);
    assign do_v      = (cmd.op == pts_pkg::SEM_V);
    assign wake_task = wake_reg;

    always_comb
    begin
        stat.p_block = dec_cnt[pts_pkg::SEM_CNT_W-1];
        stat.v_wake  = inc_cnt[pts_pkg::SEM_CNT_W-1] || (inc_cnt == '0);
        cfg_hit      = cfg_we && (cfg_index inside {[pts_pkg::CFG_SEM_BASE : CFG_SEM_LAST]});
        cfg_sem      = cfg_index - pts_pkg::CFG_SEM_BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SEM_COUNT; j++)
            begin
                count_reg[j] <= pts_pkg::SEM_CNT_W'(pts_pkg::SEM_INIT_RESET);
                head_reg[j]  <= '0;
                tail_reg[j]  <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < SEM_COUNT; j++)
            begin
                if (cfg_hit && (int'(cfg_sem) == j))
                begin
                    count_reg[j] <= pts_pkg::SEM_CNT_W'(cfg_init);
                    head_reg[j]  <= '0;
                    tail_reg[j]  <= '0;
                end
                else if (int'(sel_idx) == j)
                begin
                    if (do_p)
                    begin
                        count_reg[j] <= dec_cnt;
                        if (stat.p_block)
                            tail_reg[j] <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
                    end
                    else if (do_v)
                    begin
                        count_reg[j] <= inc_cnt;
                        if (stat.v_wake)
                            head_reg[j] <= (head == PTR_LAST) ? '0 : head + 1'b1;
                    end
                end
            end
        end
    end

    // A full ring simply overwrites its oldest waiter.
    always_ff @(posedge clk)
    begin
        if (do_p && stat.p_block)
            ring_mem[tail_addr] <= cmd.caller;
        if (do_v && stat.v_wake)
            wake_reg <= ring_mem[head_addr];
    end

endmodule

// ===== verif/priority_tick_scheduler_semaphores_tb.sv =====
// Self-checking testbench for the tick-budget scheduler with counting semaphores.
// Holds its own scheduler model, drives commands with random bursts and output stalls.
// Depends on pts_pkg and the priority_tick_scheduler_semaphores top level.
module priority_tick_scheduler_semaphores_tb;

    localparam int TASKS         = pts_pkg::TASK_COUNT_DEF;
    localparam int SEMS          = pts_pkg::SEM_COUNT_DEF;
    localparam int RING_SLOTS    = pts_pkg::RING_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 3000;

    localparam logic [31:0]              MS_PER_SEC   = 32'd1000;
    localparam logic [31:0]              SLEEP_CAP    = 32'd65535;
    localparam logic [pts_pkg::OP_W-1:0] OP_UNUSED_LO = pts_pkg::OP_SEM_V + 3'd1;

    typedef struct packed {
        pts_pkg::task_idx_t task_id;
        logic               idle;
        logic               blocked;
    } pick_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY
    } stall_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [pts_pkg::OP_W-1:0]       op;
    logic [pts_pkg::SLEEP_W-1:0]    sleep_ms;
    logic [pts_pkg::SEL_W-1:0]      sem_select;
    logic                           out_valid;
    logic                           out_stall;
    pts_pkg::task_idx_t             running_task;
    logic                           none_runnable;
    logic                           caller_blocked;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pts_pkg::CFG_DATA_W-1:0] cfg_data;

    // Scheduler model state and its copy of the registers.
    logic [pts_pkg::CFG_DATA_W-1:0]       prio_reg;
    logic [pts_pkg::HZ_W-1:0]             hz_reg;
    logic [pts_pkg::BUDGET_W-1:0]         tick_budget  [TASKS];
    logic [pts_pkg::SLEEP_W-1:0]          sleep_count  [TASKS];
    logic                                 blocked_mark [TASKS];
    pts_pkg::task_idx_t                   cur_task;
    logic signed [pts_pkg::SEM_CNT_W-1:0] sem_level    [SEMS];
    pts_pkg::task_idx_t                   ring_slot    [SEMS][RING_SLOTS];
    logic [2:0]                           ring_rd      [SEMS];
    logic [2:0]                           ring_wr      [SEMS];

    pick_t       pending_picks[$];
    int          failures;
    int          quiet_cycles;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;

    priority_tick_scheduler_semaphores i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .sleep_ms       (sleep_ms),
        .sem_select     (sem_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running_task   (running_task),
        .none_runnable  (none_runnable),
        .caller_blocked (caller_blocked),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic is_free(input int t);
        return !blocked_mark[t] && sleep_count[t] == '0;
    endfunction

    function automatic int best_runnable();
        int                           best;
        logic [pts_pkg::BUDGET_W-1:0] best_budget;
        best = -1;
        best_budget = '0;
        for (int t = 0; t < TASKS; t++)
        begin
            if (is_free(t) && tick_budget[t] > best_budget)
            begin
                best_budget = tick_budget[t];
                best = t;
            end
        end
        return best;
    endfunction

    // Returns 1 when no task could be picked, even after a budget reload.
    function automatic logic schedule_round();
        int pick;
        for (int t = 0; t < TASKS; t++)
        begin
            if (sleep_count[t] != '0)
                sleep_count[t] = sleep_count[t] - 1'b1;
        end
        pick = best_runnable();
        if (pick < 0)
        begin
            for (int t = 0; t < TASKS; t++)
            begin
                if (is_free(t))
                    tick_budget[t] = prio_reg[8*t +: 8];
            end
            pick = best_runnable();
        end
        if (pick < 0)
            return 1'b1;
        cur_task = pts_pkg::task_idx_t'(pick);
        return 1'b0;
    endfunction

    function automatic pick_t advance_scheduler(input logic [pts_pkg::OP_W-1:0] cmd,
                                                input logic [pts_pkg::SLEEP_W-1:0] ms,
                                                input logic [pts_pkg::SEL_W-1:0] sel);
        pick_t              res;
        logic [31:0]        ticks;
        pts_pkg::task_idx_t woken;
        res.idle = 1'b0;
        res.blocked = 1'b0;
        case (cmd)
            pts_pkg::OP_TICK:
            begin
                if (tick_budget[cur_task] != '0)
                    tick_budget[cur_task] = tick_budget[cur_task] - 1'b1;
                res.idle = schedule_round();
            end
            pts_pkg::OP_SCHED:
                res.idle = schedule_round();
            pts_pkg::OP_SLEEP:
            begin
                ticks = (32'(ms) * 32'(hz_reg)) / MS_PER_SEC;
                sleep_count[cur_task] = (ticks > SLEEP_CAP) ? SLEEP_CAP[15:0] : ticks[15:0];
                res.idle = schedule_round();
            end
            pts_pkg::OP_SEM_P:
            begin
                if (sem_level[sel] > pts_pkg::SEM_MIN)
                    sem_level[sel] = sem_level[sel] - 8'sd1;
                if (sem_level[sel] < 0)
                begin
                    ring_slot[sel][ring_wr[sel]] = cur_task;
                    ring_wr[sel] = ring_wr[sel] + 1'b1;
                    blocked_mark[cur_task] = 1'b1;
                    res.blocked = 1'b1;
                    res.idle = schedule_round();
                end
            end
            pts_pkg::OP_SEM_V:
            begin
                if (sem_level[sel] < pts_pkg::SEM_MAX)
                    sem_level[sel] = sem_level[sel] + 8'sd1;
                if (sem_level[sel] <= 0)
                begin
                    woken = ring_slot[sel][ring_rd[sel]];
                    blocked_mark[woken] = 1'b0;
                    ring_rd[sel] = ring_rd[sel] + 1'b1;
                    res.idle = schedule_round();
                end
            end
            default:
                ;
        endcase
        res.task_id = cur_task;
        return res;
    endfunction

    function automatic int waiting_tasks();
        int n;
        n = 0;
        for (int t = 0; t < TASKS; t++)
            n += blocked_mark[t];
        return n;
    endfunction

    always @(posedge clk)
    begin : check_results
        pick_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result beat: running_task %0d", running_task);
                failures++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (running_task !== want.task_id)
                begin
                    $error("running_task: expected %0d, actual %0d", want.task_id, running_task);
                    failures++;
                end
                if (none_runnable !== want.idle)
                begin
                    $error("none_runnable: expected %0b, actual %0b", want.idle, none_runnable);
                    failures++;
                end
                if (caller_blocked !== want.blocked)
                begin
                    $error("caller_blocked: expected %0b, actual %0b",
                           want.blocked, caller_blocked);
                    failures++;
                end
            end
        end
    end

    // The receiver switches between free-running, sparse stalls and heavy stalls.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_span <= $urandom_range(30, 200);
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
            default:      out_stall <= ($urandom_range(0, 15) < 12);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [pts_pkg::OP_W-1:0] cmd,
                             input logic [pts_pkg::SLEEP_W-1:0] ms,
                             input logic [pts_pkg::SEL_W-1:0] sel);
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= cmd;
        sleep_ms   <= ms;
        sem_select <= sel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_picks.push_back(advance_scheduler(cmd, ms, sel));
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        idle_input(1);
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [pts_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pts_pkg::CFG_DATA_W-1:0] value);
        logic [pts_pkg::SEL_W-1:0] sem_idx;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pts_pkg::CFG_PRIO: prio_reg = value;
            pts_pkg::CFG_HZ:   hz_reg = value[pts_pkg::HZ_W-1:0];
            default:
            begin
                sem_idx = pts_pkg::SEL_W'(idx - pts_pkg::CFG_SEM_BASE);
                sem_level[sem_idx] = {4'b0, value[pts_pkg::SEM_INIT_W-1:0]};
                ring_rd[sem_idx] = '0;
                ring_wr[sem_idx] = '0;
            end
        endcase
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Wakes every queued waiter so that reloading a semaphore strands no task.
    task automatic release_waiters();
        for (int s = 0; s < SEMS; s++)
        begin
            while (sem_level[s] < 0)
                send_item(pts_pkg::OP_SEM_V, pts_pkg::SLEEP_W'($urandom),
                          pts_pkg::SEL_W'(s));
        end
        wait_all_results();
    endtask

    task automatic set_config(input logic [pts_pkg::CFG_DATA_W-1:0] prio,
                              input logic [pts_pkg::HZ_W-1:0] hz,
                              input logic [pts_pkg::SEM_INIT_W-1:0] i0,
                              input logic [pts_pkg::SEM_INIT_W-1:0] i1,
                              input logic [pts_pkg::SEM_INIT_W-1:0] i2,
                              input logic [pts_pkg::SEM_INIT_W-1:0] i3);
        release_waiters();
        write_register(pts_pkg::CFG_PRIO, prio);
        write_register(pts_pkg::CFG_HZ, {54'b0, hz});
        write_register(pts_pkg::CFG_SEM_BASE, {60'b0, i0});
        write_register(pts_pkg::CFG_SEM_BASE + 3'd1, {60'b0, i1});
        write_register(pts_pkg::CFG_SEM_BASE + 3'd2, {60'b0, i2});
        write_register(pts_pkg::CFG_SEM_BASE + 3'd3, {60'b0, i3});
    endtask

    task automatic test_power_on_defaults();
        send_item(pts_pkg::OP_SCHED, '0, '0);
        send_item(pts_pkg::OP_TICK, '0, '0);
        send_item(pts_pkg::OP_TICK, '1, '1);
        for (int k = 0; k < 3; k++)
            send_item(OP_UNUSED_LO + pts_pkg::OP_W'(k), '1, '1);
        send_item(pts_pkg::OP_SCHED, '1, '0);
    endtask

    task automatic test_semaphore_ops();
        for (int s = 0; s < SEMS; s++)
            send_item(pts_pkg::OP_SEM_P, '0, pts_pkg::SEL_W'(s));
        // Semaphore 0 is now at zero, so the next P blocks the caller.
        send_item(pts_pkg::OP_SEM_P, '0, '0);
        send_item(pts_pkg::OP_SEM_V, '0, '0);
        for (int s = 1; s < SEMS; s++)
            send_item(pts_pkg::OP_SEM_V, '0, pts_pkg::SEL_W'(s));
    endtask

    task automatic test_sleep_conversion();
        wait_all_results();
        write_register(pts_pkg::CFG_HZ, '0);
        send_item(pts_pkg::OP_SLEEP, '1, '0);
        wait_all_results();
        write_register(pts_pkg::CFG_HZ, 64'd1000);
        send_item(pts_pkg::OP_SLEEP, 16'd5, '0);
        send_item(pts_pkg::OP_SCHED, '0, '0);
    endtask

    task automatic test_all_zero_priorities();
        wait_all_results();
        write_register(pts_pkg::CFG_PRIO, '0);
        // Budgets drain to zero and the reload brings nothing back.
        repeat (9) send_item(pts_pkg::OP_TICK, pts_pkg::SLEEP_W'($urandom),
                             pts_pkg::SEL_W'($urandom));
    endtask

    task automatic run_random(input int count);
        int                          burst;
        int                          roll;
        int                          ms_cap;
        int                          short_sem;
        logic [pts_pkg::OP_W-1:0]    cmd;
        logic [pts_pkg::SLEEP_W-1:0] ms;
        logic [pts_pkg::SEL_W-1:0]   sel;
        burst = 0;
        repeat (count)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 15) == 0)
                    wait_all_results();
                else if ($urandom_range(0, 3) != 0)
                    idle_input($urandom_range(1, 10));
            end
            burst--;
            roll = $urandom_range(0, 99);
            ms = pts_pkg::SLEEP_W'($urandom);
            sel = pts_pkg::SEL_W'($urandom);
            short_sem = -1;
            for (int s = 0; s < SEMS; s++)
            begin
                if (sem_level[s] < 0 && (short_sem < 0 || $urandom_range(0, 1) == 1))
                    short_sem = s;
            end
            // Favor releasing waiters so that most tasks stay schedulable.
            if (short_sem >= 0 && (waiting_tasks() >= 5
                || (roll >= 72 && roll < 94 && $urandom_range(0, 9) < 7)))
            begin
                cmd = pts_pkg::OP_SEM_V;
                sel = pts_pkg::SEL_W'(short_sem);
            end
            else if (roll < 26)
                cmd = pts_pkg::OP_TICK;
            else if (roll < 40)
                cmd = pts_pkg::OP_SCHED;
            else if (roll < 54)
            begin
                // Keep sleeps to a few dozen ticks at the current rate.
                cmd = pts_pkg::OP_SLEEP;
                ms_cap = (hz_reg == '0) ? 65535 : 40000 / hz_reg;
                if (ms_cap > 65535)
                    ms_cap = 65535;
                ms = pts_pkg::SLEEP_W'($urandom_range(0, ms_cap));
            end
            else if (roll < 72)
                cmd = pts_pkg::OP_SEM_P;
            else if (roll < 94)
                cmd = pts_pkg::OP_SEM_V;
            else
                cmd = OP_UNUSED_LO + pts_pkg::OP_W'($urandom_range(0, 2));
            send_item(cmd, ms, sel);
        end
    endtask

    function automatic logic [pts_pkg::CFG_DATA_W-1:0] sparse_priorities();
        logic [pts_pkg::CFG_DATA_W-1:0] p;
        for (int t = 0; t < TASKS; t++)
            p[8*t +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        return p;
    endfunction

    task automatic test_random_phases();
        set_config({$urandom, $urandom}, 10'd1, 4'd0, 4'd1, 4'd2, 4'd15);
        run_random(130);
        set_config('1, 10'd1023, 4'd0, 4'd0, 4'd0, 4'd0);
        run_random(130);
        set_config(sparse_priorities(), pts_pkg::HZ_W'($urandom_range(1, 1000)),
                   pts_pkg::SEM_INIT_W'($urandom), pts_pkg::SEM_INIT_W'($urandom),
                   pts_pkg::SEM_INIT_W'($urandom), pts_pkg::SEM_INIT_W'($urandom));
        run_random(130);
        set_config(sparse_priorities(), 10'd0, 4'd3, 4'd1, 4'd15, 4'd7);
        run_random(130);
    endtask

    // Runs last: it leaves tasks stranded in overwritten rings and asleep for good.
    task automatic test_count_limits();
        release_waiters();
        write_register(pts_pkg::CFG_PRIO, '1);
        write_register(pts_pkg::CFG_SEM_BASE + 3'd1, 64'd15);
        write_register(pts_pkg::CFG_SEM_BASE + 3'd3, 64'd0);
        repeat (113) send_item(pts_pkg::OP_SEM_V, pts_pkg::SLEEP_W'($urandom), 2'd1);
        send_item(pts_pkg::OP_SEM_P, '0, 2'd1);
        repeat (130) send_item(pts_pkg::OP_SEM_P, pts_pkg::SLEEP_W'($urandom), 2'd3);
        repeat (128) send_item(pts_pkg::OP_SEM_V, pts_pkg::SLEEP_W'($urandom), 2'd3);
        wait_all_results();
        write_register(pts_pkg::CFG_HZ, 64'd1023);
        send_item(pts_pkg::OP_SLEEP, '1, '0);
        send_item(pts_pkg::OP_SCHED, '0, '0);
        send_item(pts_pkg::OP_TICK, '0, '0);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = pts_pkg::OP_TICK;
        sleep_ms   = '0;
        sem_select = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = pts_pkg::CFG_PRIO;
        cfg_data   = '0;
        failures   = 0;
        quiet_cycles = 0;
        prio_reg   = pts_pkg::PRIO_RESET;
        hz_reg     = pts_pkg::HZ_RESET;
        cur_task   = '0;
        for (int t = 0; t < TASKS; t++)
        begin
            tick_budget[t]  = '0;
            sleep_count[t]  = '0;
            blocked_mark[t] = 1'b0;
        end
        for (int s = 0; s < SEMS; s++)
        begin
            sem_level[s]    = {4'b0, pts_pkg::SEM_INIT_RESET};
            ring_rd[s]      = '0;
            ring_wr[s]      = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_power_on_defaults();
        test_semaphore_ops();
        test_sleep_conversion();
        test_all_zero_priorities();
        test_random_phases();
        test_count_limits();

        wait_all_results();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== priority_tick_scheduler_semaphores.f =====
+incdir+hw/rtl
hw/rtl/pts_pkg.sv
hw/rtl/pts_cell.sv
hw/rtl/pts_sem.sv
hw/rtl/priority_tick_scheduler_semaphores.sv
verif/priority_tick_scheduler_semaphores_tb.sv
